/* src/fss_pkg.sv */
package fss_pkg;

    localparam logic [2:0] CMD_INBOUND  = 3'd0;
    localparam logic [2:0] CMD_TICK     = 3'd1;
    localparam logic [2:0] CMD_CONNECT  = 3'd2;
    localparam logic [2:0] CMD_APP_SEND = 3'd3;
    localparam logic [2:0] CMD_LOGOUT   = 3'd4;
    localparam logic [2:0] CMD_NEW_CONN = 3'd5;

    localparam logic [2:0] KIND_LOGON     = 3'd0;
    localparam logic [2:0] KIND_HEARTBEAT = 3'd1;
    localparam logic [2:0] KIND_TEST_REQ  = 3'd2;
    localparam logic [2:0] KIND_RESEND    = 3'd3;
    localparam logic [2:0] KIND_LOGOUT    = 3'd4;
    localparam logic [2:0] KIND_SEQ_RESET = 3'd5;

    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_LOGON   = 4'd1;
    localparam logic [3:0] ACT_HB      = 4'd2;
    localparam logic [3:0] ACT_TEST    = 4'd3;
    localparam logic [3:0] ACT_RESEND  = 4'd4;
    localparam logic [3:0] ACT_REJECT  = 4'd5;
    localparam logic [3:0] ACT_LOGOUT  = 4'd6;
    localparam logic [3:0] ACT_DELIVER = 4'd7;
    localparam logic [3:0] ACT_SENT    = 4'd8;

    localparam logic [2:0] PH_DISC         = 3'd0;
    localparam logic [2:0] PH_AWAIT_LOGON  = 3'd1;
    localparam logic [2:0] PH_ACTIVE       = 3'd2;
    localparam logic [2:0] PH_AWAIT_RESEND = 3'd3;
    localparam logic [2:0] PH_AWAIT_LOGOUT = 3'd4;
    localparam logic [2:0] PH_LOGGED_OUT   = 3'd5;

    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_NO_SEQ    = 3'd1;
    localparam logic [2:0] RSN_NO_NEWSEQ = 3'd2;
    localparam logic [2:0] RSN_REVERSAL  = 3'd3;
    localparam logic [2:0] RSN_BACK_RST  = 3'd4;
    localparam logic [2:0] RSN_PEER_OUT  = 3'd5;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_REVERSAL = 2'd1;
    localparam logic [1:0] ERR_BACK_RST = 2'd2;
    localparam logic [1:0] ERR_UNRESP   = 2'd3;

    localparam logic [1:0] REG_INITIATOR = 2'd0;
    localparam logic [1:0] REG_HB_DEFAULT = 2'd1;
    localparam logic [1:0] REG_TOLERANCE = 2'd2;

    localparam int IN_BITS  = 112;
    localparam int OUT_BITS = 80;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] seq;
        logic [31:0] val;
        logic        rst;
        logic [2:0]  reason;
    } pend_t;

    typedef struct packed {
        logic load;
        logic calc1;
        logic calc2;
        logic exec;
        logic sel;
    } fss_cmd_t;

    typedef struct packed {
        logic two;
    } fss_status_t;

endpackage

/* src/fss_ctrl.sv */
module fss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_fire,
    input  fss_pkg::fss_status_t status,
    output fss_pkg::fss_cmd_t   cmd,
    output logic                s_ready,
    output logic                m_valid
);
    import fss_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CALC1, S_CALC2, S_EXEC, S_OUT} state_t;

    state_t state_reg;
    logic   idx_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= 1'b0;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg   <= S_CALC1;
                        s_ready_reg <= 1'b0;
                    end
                end
                S_CALC1: state_reg <= S_CALC2;
                S_CALC2: state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg   <= S_OUT;
                    idx_reg     <= 1'b0;
                    m_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        if (status.two && !idx_reg)
                        begin
                            idx_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg   <= S_IDLE;
                            m_valid_reg <= 1'b0;
                            s_ready_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg   <= S_IDLE;
                    m_valid_reg <= 1'b0;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign cmd.load  = in_fire;
    assign cmd.calc1 = (state_reg == S_CALC1);
    assign cmd.calc2 = (state_reg == S_CALC2);
    assign cmd.exec  = (state_reg == S_EXEC);
    assign cmd.sel   = idx_reg;
    assign s_ready   = s_ready_reg;
    assign m_valid   = m_valid_reg;
endmodule

/* src/fss_datapath.sv */
module fss_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fss_pkg::fss_cmd_t        cmd,
    output fss_pkg::fss_status_t     status,
    input  logic [2:0]               in_command,
    input  logic [fss_pkg::IN_BITS-1:0] in_data,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    output logic [3:0]               out_action,
    output logic [fss_pkg::OUT_BITS-1:0] out_data,
    output logic                     out_last
);
    import fss_pkg::*;

    // configuration
    logic        init_reg;
    logic [15:0] hb_def_reg;
    logic [9:0]  tol_reg;

    // session state
    logic [2:0]  ph_reg;
    logic [1:0]  err_reg;
    logic [31:0] ei_reg, no_reg, tc_reg;
    logic [15:0] ni_reg;
    logic [39:0] lst_reg, lrt_reg;
    logic        to_reg, rr_reg;

    // latched word
    logic [2:0]           cmd_reg;
    logic [IN_BITS-1:0]   in_reg;

    // timing precompute
    logic [39:0] els_reg, elr_reg;
    logic        ges_reg, ger_reg;
    logic [25:0] iv1k_reg;
    logic [37:0] thr1_reg, thr2_reg;

    // results
    pend_t p0_reg, p1_reg;
    logic  two_reg;

    logic [2:0]  f_kind;
    logic        f_sv, f_pd, f_rf, f_vv;
    logic [31:0] f_seq, f_val;
    logic [39:0] f_now;

    assign f_kind = in_reg[2:0];
    assign f_sv   = in_reg[3];
    assign f_seq  = in_reg[35:4];
    assign f_pd   = in_reg[36];
    assign f_rf   = in_reg[37];
    assign f_vv   = in_reg[38];
    assign f_val  = in_reg[70:39];
    assign f_now  = in_reg[110:71];

    logic [2:0]  ph_n;
    logic [1:0]  err_n;
    logic [31:0] ei_n, no_n, tc_n;
    logic [15:0] ni_n;
    logic [39:0] lst_n, lrt_n;
    logic        to_n, rr_n;
    pend_t       pv [2];
    logic [1:0]  n;
    logic        chk, is_logon, ok, own_reset;
    logic        hb_due, reach1, reach2;

    assign hb_due = ges_reg && (els_reg >= {14'd0, iv1k_reg});
    assign reach1 = ger_reg && ({elr_reg, 8'd0} >= {10'd0, thr1_reg});
    assign reach2 = ger_reg && ({elr_reg, 8'd0} >= {10'd0, thr2_reg});

    always_comb
    begin
        ph_n = ph_reg; err_n = err_reg; ei_n = ei_reg; no_n = no_reg; tc_n = tc_reg;
        ni_n = ni_reg; lst_n = lst_reg; lrt_n = lrt_reg; to_n = to_reg; rr_n = rr_reg;
        pv[0] = '0;
        pv[1] = '0;
        n = 2'd0;
        chk = 1'b0;
        is_logon = 1'b0;
        ok = 1'b0;
        own_reset = 1'b0;
        case (cmd_reg)
            CMD_INBOUND:
            begin
                lrt_n = f_now;
                if (f_kind == KIND_LOGON)
                begin
                    is_logon = 1'b1;
                    own_reset = rr_n;
                    rr_n = 1'b0;
                    if (f_rf && !own_reset)
                    begin
                        ei_n = 32'd1;
                        no_n = 32'd1;
                    end
                    if (f_vv)
                    begin
                        ni_n = (f_val > 32'd65535) ? 16'hFFFF : f_val[15:0];
                    end
                    if (!init_reg && ph_n == PH_DISC)
                    begin
                        pv[n[0]] = '{ACT_LOGON, no_n, {16'd0, ni_n}, f_rf, RSN_NONE};
                        n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                    end
                    chk = 1'b1;
                end
                else if (ph_n != PH_DISC)
                begin
                    if (f_kind == KIND_SEQ_RESET)
                    begin
                        if (!f_vv)
                        begin
                            pv[n[0]] = '{ACT_REJECT, no_n, f_sv ? f_seq : 32'd0, 1'b0,
                                         RSN_NO_NEWSEQ};
                            n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                        end
                        else if (f_val < ei_n)
                        begin
                            err_n = ERR_BACK_RST;
                            pv[n[0]] = '{ACT_LOGOUT, no_n, 32'd0, 1'b0, RSN_BACK_RST};
                            n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                            ph_n = PH_LOGGED_OUT;
                        end
                        else
                        begin
                            ei_n = f_val;
                            if (ph_n == PH_AWAIT_RESEND)
                            begin
                                ph_n = PH_ACTIVE;
                            end
                        end
                    end
                    else
                    begin
                        chk = 1'b1;
                    end
                end
                if (chk)
                begin
                    if (!f_sv)
                    begin
                        pv[n[0]] = '{ACT_REJECT, no_n, 32'd0, 1'b0, RSN_NO_SEQ};
                        n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                    end
                    else if (f_seq == ei_n)
                    begin
                        ei_n = f_seq + 32'd1;
                        ok = 1'b1;
                    end
                    else if (f_seq < ei_n)
                    begin
                        if (!f_pd)
                        begin
                            err_n = ERR_REVERSAL;
                            pv[n[0]] = '{ACT_LOGOUT, no_n, 32'd0, 1'b0, RSN_REVERSAL};
                            n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                            ph_n = PH_LOGGED_OUT;
                        end
                    end
                    else if (ph_n != PH_AWAIT_RESEND)
                    begin
                        ph_n = PH_AWAIT_RESEND;
                        pv[n[0]] = '{ACT_RESEND, no_n, ei_n, 1'b0, RSN_NONE};
                        n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                    end
                end
                if (ok)
                begin
                    if (is_logon)
                    begin
                        ph_n = PH_ACTIVE;
                    end
                    else
                    begin
                        case (f_kind)
                            KIND_HEARTBEAT:
                            begin
                                if (to_n && f_vv && f_val == tc_n)
                                begin
                                    to_n = 1'b0;
                                end
                            end
                            KIND_TEST_REQ:
                            begin
                                pv[n[0]] = '{ACT_HB, no_n, f_vv ? f_val : 32'd0, 1'b0,
                                             RSN_NONE};
                                n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                            end
                            KIND_RESEND: ;
                            KIND_LOGOUT:
                            begin
                                if (ph_n != PH_AWAIT_LOGOUT)
                                begin
                                    pv[n[0]] = '{ACT_LOGOUT, no_n, 32'd0, 1'b0, RSN_PEER_OUT};
                                    n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                                end
                                ph_n = PH_LOGGED_OUT;
                            end
                            default:
                            begin
                                pv[n[0]] = '{ACT_DELIVER, 32'd0, 32'd0, 1'b0, RSN_NONE};
                                n = n + 2'd1;
                            end
                        endcase
                    end
                end
            end
            CMD_TICK:
            begin
                if (ph_reg != PH_DISC && ph_reg != PH_LOGGED_OUT && ni_reg != 16'd0)
                begin
                    if (hb_due)
                    begin
                        pv[n[0]] = '{ACT_HB, no_n, 32'd0, 1'b0, RSN_NONE};
                        n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                    end
                    if (to_reg)
                    begin
                        if (reach2)
                        begin
                            err_n = ERR_UNRESP;
                            ph_n = PH_LOGGED_OUT;
                        end
                    end
                    else if (reach1)
                    begin
                        tc_n = tc_reg + 32'd1;
                        pv[n[0]] = '{ACT_TEST, no_n, tc_n, 1'b0, RSN_NONE};
                        n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                        to_n = 1'b1;
                    end
                end
            end
            CMD_CONNECT:
            begin
                if (init_reg)
                begin
                    if (f_rf)
                    begin
                        ei_n = 32'd1;
                        no_n = 32'd1;
                    end
                    rr_n = f_rf;
                    pv[n[0]] = '{ACT_LOGON, no_n, {16'd0, ni_n}, f_rf, RSN_NONE};
                    n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                    ph_n = PH_AWAIT_LOGON;
                    lrt_n = f_now;
                end
            end
            CMD_APP_SEND:
            begin
                if (ph_reg == PH_ACTIVE)
                begin
                    pv[n[0]] = '{ACT_SENT, no_n, 32'd0, 1'b0, RSN_NONE};
                    n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                end
            end
            CMD_LOGOUT:
            begin
                pv[n[0]] = '{ACT_LOGOUT, no_n, 32'd0, 1'b0, RSN_NONE};
                n = n + 2'd1; no_n = no_n + 32'd1; lst_n = f_now;
                ph_n = PH_AWAIT_LOGOUT;
            end
            CMD_NEW_CONN:
            begin
                ph_n = PH_DISC;
                err_n = ERR_NONE;
                lst_n = 40'd0;
                lrt_n = 40'd0;
                to_n = 1'b0;
                rr_n = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_command;
            in_reg  <= in_data;
        end
        if (cmd.calc1)
        begin
            ges_reg  <= (f_now >= lst_reg);
            els_reg  <= f_now - lst_reg;
            ger_reg  <= (f_now >= lrt_reg);
            elr_reg  <= f_now - lrt_reg;
            iv1k_reg <= 26'(ni_reg * 26'd1000);
        end
        if (cmd.calc2)
        begin
            thr1_reg <= 38'(iv1k_reg * (12'd256 + {2'd0, tol_reg}));
            thr2_reg <= 38'(iv1k_reg * (12'd256 + {1'b0, tol_reg, 1'b0}));
        end
        if (cmd.exec)
        begin
            p0_reg  <= pv[0];
            p1_reg  <= pv[1];
            two_reg <= (n == 2'd2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= 1'b1;
            hb_def_reg <= 16'd30;
            tol_reg    <= 10'd51;
            ph_reg     <= PH_DISC;
            err_reg    <= ERR_NONE;
            ei_reg     <= 32'd1;
            no_reg     <= 32'd1;
            ni_reg     <= 16'd30;
            lst_reg    <= 40'd0;
            lrt_reg    <= 40'd0;
            to_reg     <= 1'b0;
            tc_reg     <= 32'd0;
            rr_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                ph_reg  <= ph_n;
                err_reg <= err_n;
                ei_reg  <= ei_n;
                no_reg  <= no_n;
                ni_reg  <= ni_n;
                lst_reg <= lst_n;
                lrt_reg <= lrt_n;
                to_reg  <= to_n;
                tc_reg  <= tc_n;
                rr_reg  <= rr_n;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INITIATOR: init_reg <= cfg_data[0];
                    REG_HB_DEFAULT:
                    begin
                        hb_def_reg <= cfg_data;
                        ni_reg     <= cfg_data;
                    end
                    REG_TOLERANCE: tol_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    pend_t cur;
    assign cur = cmd.sel ? p1_reg : p0_reg;
    // empty result list: p0 is all zeros, which reads as action none
    assign out_action = cur.action;
    assign out_data = {7'd0, err_reg, ph_reg, cur.reason, cur.rst, cur.val, cur.seq};
    assign out_last = cmd.sel || !two_reg;
    assign status.two = two_reg;
endmodule

/* src/fix_session_sequencer_unit.sv */
// FIX session sequencer: one event word in, one or two action words out.
// An accepted event passes through the CALC1, CALC2 and EXEC states before the first output word.
// The controller handles one event at a time: a new event is accepted only after the
// last output word is taken, so an output stall also holds back the input.
// Reset (rst_n low, asynchronous): session disconnected, both sequence
// numbers 1, registers at initiator=1, heartbeat 30 s, tolerance 51/256.
module fix_session_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    // inbound event words
    input  logic         s_tvalid,
    output logic         s_tready,
    // msg_kind[2:0], seq_valid[3], seq_num[35:4], poss_dup[36], reset_flag[37],
    // value_valid[38], value[70:39], now_ms[110:71], zero fill [111]
    input  logic [111:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    // action words
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_seq[31:0], action_value[63:32], reset_out[64], reason_code[67:65],
    // session_state[70:68], error_code[72:71], zero fill [79:73]
    output logic [79:0]  m_tdata,
    // action[3:0]
    output logic [3:0]   m_tuser,
    output logic         m_tlast,
    // register writes: 0 initiator, 1 heartbeat_default_s, 2 tolerance_q8
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import fss_pkg::*;

    fss_cmd_t    cmd;
    fss_status_t status;
    logic        in_fire, out_fire;

    // accept a word only in idle; hold results until the sink takes them
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    fss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    // datapath: latch the word, take elapsed times, form thresholds, apply the event
    fss_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_command (s_tuser),
        .in_data    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_action (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );
endmodule

/* src/fss_checker.sv */
module fss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while results pending");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("no return to idle after final word");

    a_act: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= 4'd8)
        else $error("action code out of range");
endmodule

bind fix_session_sequencer_unit fss_checker u_fss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
